/* sv/cbrb_pkg.sv */
package cbrb_pkg;

  // Storage and field geometry.
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned MAX_READ = 64;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned BSZ_W    = 11;
  localparam int unsigned INIT_W   = 10;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned POS_W    = 63;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned SZ_W     = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam int unsigned RCNT_W   = $clog2(MAX_READ + 1);
  localparam int unsigned DIV_CW   = $clog2(INIT_W);

  // Operation codes.
  localparam logic [1:0] OP_OPEN = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [1:0] STAT_SHORT     = 2'd2;

  // Result kinds.
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Register indexes.
  localparam logic [CIDX_W-1:0] REG_BUFFER_SIZE      = 2'd0;
  localparam logic [CIDX_W-1:0] REG_INITIAL_POSITION = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       div_step;
    logic       open_clear;
    logic       open_arm;
    logic       append_byte;
    logic       read_arm;
    logic       read_byte;
    logic       emit;
    logic       emit_kind;
    logic [1:0] emit_status;
    logic       emit_last;
    logic       emit_mem;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic open_too_large;
    logic open_no_room;
    logic len_zero;
    logic read_too_large;
    logic read_short;
    logic chunk_open;
    logic chunk_final;
    logic run_last;
    logic div_last;
  } stat_t;

endpackage

/* sv/chunked_byte_ring_buffer.sv */
// Chunked byte ring buffer: a byte store addressed by 63-bit positions
// that grow without end, each living in slot (position mod buffer size).
// An item is accepted on a rising edge with start high, busy low and no
// configuration write. An open item checks its length against the size
// and the free room; data items then store one byte per cycle, and the
// final byte commits the write position. Acknowledgments and errors
// appear in the cycle after the item is accepted. A read item of n bytes
// enters the read state, which keeps busy high and streams n results on
// back-to-back cycles unless a configuration write ends the run; all
// other items leave busy low. The byte store has one read and one write
// address per cycle, which sets the read rate at one byte per cycle.
// Results are strobed by result_valid_o for exactly one cycle; the receiver
// cannot stall them, so nothing here waits on it.
// Configuration writes are always taken (cfg_ready_o stays high). A write
// to either register reloads both positions with initial_position mod size,
// computed by a restoring divider in the divide state, while busy is high.
// Writes to other indexes are ignored. After reset the size is 1024, both
// positions are zero and no chunk is open; the store contents are undefined.
module chunked_byte_ring_buffer import cbrb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation_i,
  input  logic [LEN_W-1:0]    length_i,
  input  logic [DATA_W-1:0]   data_in_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CIDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  output logic                result_valid_o,
  output logic                result_kind_o,
  output logic [1:0]          status_o,
  output logic [DATA_W-1:0]   data_out_o,
  output logic                last_o,
  output logic [POS_W-1:0]    read_position_out_o,
  output logic [POS_W-1:0]    write_position_out_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;
  logic  accept;

  // The configuration channel never pushes back.
  assign cfg_ready_o = 1'b1;

  // Only the two defined registers cause a reload.
  assign cfg_we = cfg_valid_i && cfg_ready_o &&
                  ((cfg_index_i == REG_BUFFER_SIZE) ||
                   (cfg_index_i == REG_INITIAL_POSITION));

  // Start is only looked at while idle; the controller ignores it otherwise.
  assign accept = start && !busy;

  cbrb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .op_i     (operation_i),
    .cfg_we_i (cfg_we),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  cbrb_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .length_i             (length_i),
    .data_in_i            (data_in_i),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .result_valid_o       (result_valid_o),
    .result_kind_o        (result_kind_o),
    .status_o             (status_o),
    .data_out_o           (data_out_o),
    .last_o               (last_o),
    .read_position_out_o  (read_position_out_o),
    .write_position_out_o (write_position_out_o)
  );

`ifndef SYNTH
  // Every result follows an accepted item or a cycle of a read run.
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(accept) || $past(busy)))
    else $error("result without an accepted item or active run");

  // A successful result never shows more data buffered than the store holds.
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == STAT_OK)) |->
      ((write_position_out_o - read_position_out_o) <= POS_W'(DEPTH)))
    else $error("fill level exceeds the store depth");

  // While more read bytes are due, the block must still be busy.
  a_run_keeps_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_kind_o == KIND_READ) && !last_o) |-> busy)
    else $error("read run ended before its last byte");
`endif

endmodule

/* sv/cbrb_ctrl.sv */
module cbrb_ctrl import cbrb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] op_i,
  input  logic       cfg_we_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        priority if (cfg_we_i) begin
          state_d = S_DIV;
        end else if (start_i) begin
          unique case (op_i)
            OP_OPEN: begin
              cmd_o.open_clear = 1'b1;
              cmd_o.emit_kind  = KIND_APPEND;
              cmd_o.emit_last  = 1'b1;
              priority if (stat_i.open_too_large) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STAT_TOO_LARGE;
              end else if (stat_i.open_no_room) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STAT_SHORT;
              end else if (stat_i.len_zero) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STAT_OK;
              end else begin
                cmd_o.open_arm = 1'b1;
              end
            end
            OP_DATA: begin
              cmd_o.append_byte = stat_i.chunk_open;
              cmd_o.emit        = stat_i.chunk_final;
              cmd_o.emit_kind   = KIND_APPEND;
              cmd_o.emit_status = STAT_OK;
              cmd_o.emit_last   = 1'b1;
            end
            OP_READ: begin
              cmd_o.emit_kind = KIND_READ;
              cmd_o.emit_last = 1'b1;
              priority if (stat_i.read_too_large) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STAT_TOO_LARGE;
              end else if (stat_i.read_short) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STAT_SHORT;
              end else if (stat_i.len_zero) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STAT_OK;
              end else begin
                cmd_o.read_arm = 1'b1;
                state_d        = S_READ;
              end
            end
            OP_NOP: begin
            end
            default: begin
            end
          endcase
        end else begin
        end
      end
      S_READ: begin
        if (cfg_we_i) begin
          state_d = S_DIV;
        end else begin
          cmd_o.read_byte   = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_kind   = KIND_READ;
          cmd_o.emit_status = STAT_OK;
          cmd_o.emit_last   = stat_i.run_last;
          cmd_o.emit_mem    = 1'b1;
          if (stat_i.run_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (!cfg_we_i) begin
          cmd_o.div_step = 1'b1;
          if (stat_i.div_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/cbrb_dp.sv */
module cbrb_dp import cbrb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CIDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic [LEN_W-1:0]        length_i,
  input  logic [DATA_W-1:0]       data_in_i,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  output logic                    result_valid_o,
  output logic                    result_kind_o,
  output logic [1:0]              status_o,
  output logic [DATA_W-1:0]       data_out_o,
  output logic                    last_o,
  output logic [POS_W-1:0]        read_position_out_o,
  output logic [POS_W-1:0]        write_position_out_o
);

  logic [SZ_W-1:0]   size_q, size_d;
  logic [INIT_W-1:0] init_q, init_d;
  logic [POS_W-1:0]  rd_pos_q, rd_pos_d, wr_pos_q, wr_pos_d, cur_pos_q, cur_pos_d;
  logic [AW-1:0]     rd_slot_q, rd_slot_d, wr_slot_q, wr_slot_d, cur_slot_q, cur_slot_d;
  logic [SZ_W-1:0]   fill_q, fill_d;
  logic [LEN_W-1:0]  remain_q, remain_d, chunk_q, chunk_d;
  logic [RCNT_W-1:0] rcnt_q, rcnt_d;
  logic [SZ_W-1:0]   div_rem_q, div_rem_d;
  logic [INIT_W-1:0] div_dvd_q, div_dvd_d;
  logic [DIV_CW-1:0] div_cnt_q, div_cnt_d;

  logic [SZ_W-1:0]   len_ext, bsz_ext, div_trial, div_next;
  logic [SZ_W:0]     room_sum;
  logic [AW-1:0]     rd_slot_inc, cur_slot_inc;

  logic              out_valid_q, out_kind_q, out_last_q, out_mem_q;
  logic [1:0]        out_status_q;
  logic [POS_W-1:0]  out_rpos_q, out_wpos_q;
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] mem_rd_q;

  // Advance a slot index, wrapping at the configured size.
  function automatic logic [AW-1:0] slot_inc(logic [AW-1:0] slot, logic [SZ_W-1:0] size);
    logic [SZ_W-1:0] nxt;
    nxt = SZ_W'(slot) + SZ_W'(1);
    return (nxt == size) ? '0 : nxt[AW-1:0];
  endfunction

  assign len_ext      = SZ_W'(length_i);
  assign bsz_ext      = SZ_W'(cfg_data_i[BSZ_W-1:0]);
  assign room_sum     = {1'b0, fill_q} + {1'b0, len_ext};
  assign rd_slot_inc  = slot_inc(rd_slot_q, size_q);
  assign cur_slot_inc = slot_inc(cur_slot_q, size_q);

  // One restoring step of initial_position mod size.
  assign div_trial = {div_rem_q[SZ_W-2:0], div_dvd_q[INIT_W-1]};
  assign div_next  = (div_trial >= size_q) ? (div_trial - size_q) : div_trial;

  always_comb begin
    stat_o.open_too_large = (len_ext > size_q);
    stat_o.open_no_room   = (room_sum > {1'b0, size_q});
    stat_o.len_zero       = (length_i == '0);
    stat_o.read_too_large = (len_ext > size_q) || (length_i > LEN_W'(MAX_READ));
    stat_o.read_short     = (len_ext > fill_q);
    stat_o.chunk_open     = (remain_q != '0);
    stat_o.chunk_final    = (remain_q == LEN_W'(1));
    stat_o.run_last       = (rcnt_q == RCNT_W'(1));
    stat_o.div_last       = (div_cnt_q == DIV_CW'(INIT_W - 1));
  end

  always_comb begin
    size_d     = size_q;
    init_d     = init_q;
    rd_pos_d   = rd_pos_q;
    wr_pos_d   = wr_pos_q;
    cur_pos_d  = cur_pos_q;
    rd_slot_d  = rd_slot_q;
    wr_slot_d  = wr_slot_q;
    cur_slot_d = cur_slot_q;
    fill_d     = fill_q;
    remain_d   = remain_q;
    chunk_d    = chunk_q;
    rcnt_d     = rcnt_q;
    div_rem_d  = div_rem_q;
    div_dvd_d  = div_dvd_q;
    div_cnt_d  = div_cnt_q;

    if (cfg_we_i) begin
      if (cfg_index_i == REG_BUFFER_SIZE) begin
        priority if (bsz_ext == '0) begin
          size_d = SZ_W'(1);
        end else if (bsz_ext > SZ_W'(DEPTH)) begin
          size_d = SZ_W'(DEPTH);
        end else begin
          size_d = bsz_ext;
        end
      end else begin
        init_d = cfg_data_i[INIT_W-1:0];
      end
      remain_d  = '0;
      rcnt_d    = '0;
      div_rem_d = '0;
      div_dvd_d = init_d;
      div_cnt_d = '0;
    end else begin
      if (cmd_i.div_step) begin
        div_rem_d = div_next;
        div_dvd_d = {div_dvd_q[INIT_W-2:0], 1'b0};
        div_cnt_d = div_cnt_q + DIV_CW'(1);
        if (stat_o.div_last) begin
          rd_pos_d  = POS_W'(div_next);
          wr_pos_d  = POS_W'(div_next);
          rd_slot_d = div_next[AW-1:0];
          wr_slot_d = div_next[AW-1:0];
          fill_d    = '0;
        end
      end
      if (cmd_i.open_clear) begin
        remain_d = '0;
      end
      if (cmd_i.open_arm) begin
        remain_d   = length_i;
        chunk_d    = length_i;
        cur_pos_d  = wr_pos_q;
        cur_slot_d = wr_slot_q;
      end
      if (cmd_i.append_byte) begin
        cur_pos_d  = cur_pos_q + POS_W'(1);
        cur_slot_d = cur_slot_inc;
        remain_d   = remain_q - LEN_W'(1);
        if (stat_o.chunk_final) begin
          wr_pos_d  = cur_pos_d;
          wr_slot_d = cur_slot_inc;
          fill_d    = fill_q + SZ_W'(chunk_q);
        end
      end
      if (cmd_i.read_arm) begin
        rcnt_d = length_i[RCNT_W-1:0];
      end
      if (cmd_i.read_byte) begin
        rd_pos_d  = rd_pos_q + POS_W'(1);
        rd_slot_d = rd_slot_inc;
        fill_d    = fill_q - SZ_W'(1);
        rcnt_d    = rcnt_q - RCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SZ_W'(DEPTH);
      init_q      <= '0;
      rd_pos_q    <= '0;
      wr_pos_q    <= '0;
      cur_pos_q   <= '0;
      rd_slot_q   <= '0;
      wr_slot_q   <= '0;
      cur_slot_q  <= '0;
      fill_q      <= '0;
      remain_q    <= '0;
      chunk_q     <= '0;
      rcnt_q      <= '0;
      div_rem_q   <= '0;
      div_dvd_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      size_q      <= size_d;
      init_q      <= init_d;
      rd_pos_q    <= rd_pos_d;
      wr_pos_q    <= wr_pos_d;
      cur_pos_q   <= cur_pos_d;
      rd_slot_q   <= rd_slot_d;
      wr_slot_q   <= wr_slot_d;
      cur_slot_q  <= cur_slot_d;
      fill_q      <= fill_d;
      remain_q    <= remain_d;
      chunk_q     <= chunk_d;
      rcnt_q      <= rcnt_d;
      div_rem_q   <= div_rem_d;
      div_dvd_q   <= div_dvd_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= cmd_i.emit && !cfg_we_i;
    end
  end

  // Result payload registers; positions are taken after this cycle's update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q   <= cmd_i.emit_kind;
      out_status_q <= cmd_i.emit_status;
      out_last_q   <= cmd_i.emit_last;
      out_mem_q    <= cmd_i.emit_mem;
      out_rpos_q   <= rd_pos_d;
      out_wpos_q   <= wr_pos_d;
    end
  end

  // Byte store: one write port for appends, one registered read for reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append_byte && !cfg_we_i) begin
      mem_q[cur_slot_q] <= data_in_i;
    end
    if (cmd_i.read_byte && !cfg_we_i) begin
      mem_rd_q <= mem_q[rd_slot_q];
    end
  end

  assign result_valid_o       = out_valid_q;
  assign result_kind_o        = out_kind_q;
  assign status_o             = out_status_q;
  assign last_o               = out_last_q;
  assign data_out_o           = out_mem_q ? mem_rd_q : '0;
  assign read_position_out_o  = out_rpos_q;
  assign write_position_out_o = out_wpos_q;

endmodule
